### hdl/jts_pkg.sv
// Shared types, opcodes, TAP state codes and TAP graph tables for the JTAG sequencer.
// No dependencies; every other file of the block imports this package.
package jts_pkg;

	localparam int SHIFT_WIDTH  = 32;
	localparam int MAX_IDLE     = 64;
	localparam int RESET_CLOCKS = 6;
	localparam int DATA_W       = 32;
	localparam int CNT_W        = 7;

	typedef logic [1:0]       op_t;
	typedef logic [3:0]       tap_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam op_t OP_GOTO  = 2'd0;
	localparam op_t OP_RESET = 2'd1;
	localparam op_t OP_SHIFT = 2'd2;
	localparam op_t OP_IDLE  = 2'd3;

	localparam tap_t ST_TLR       = 4'd0;
	localparam tap_t ST_RTI       = 4'd1;
	localparam tap_t ST_SEL_DR    = 4'd2;
	localparam tap_t ST_CAP_DR    = 4'd3;
	localparam tap_t ST_SHIFT_DR  = 4'd4;
	localparam tap_t ST_EXIT1_DR  = 4'd5;
	localparam tap_t ST_PAUSE_DR  = 4'd6;
	localparam tap_t ST_EXIT2_DR  = 4'd7;
	localparam tap_t ST_UPD_DR    = 4'd8;
	localparam tap_t ST_SEL_IR    = 4'd9;
	localparam tap_t ST_CAP_IR    = 4'd10;
	localparam tap_t ST_SHIFT_IR  = 4'd11;
	localparam tap_t ST_EXIT1_IR  = 4'd12;
	localparam tap_t ST_PAUSE_IR  = 4'd13;
	localparam tap_t ST_EXIT2_IR  = 4'd14;
	localparam tap_t ST_UPD_IR    = 4'd15;

	// TAP graph: next state for TMS low and TMS high
	localparam tap_t NEXT_TMS0 [16] = '{4'd1, 4'd1, 4'd3, 4'd4, 4'd4, 4'd6, 4'd6, 4'd4,
		4'd1, 4'd10, 4'd11, 4'd11, 4'd13, 4'd13, 4'd11, 4'd1};
	localparam tap_t NEXT_TMS1 [16] = '{4'd0, 4'd2, 4'd9, 4'd5, 4'd5, 4'd8, 4'd7, 4'd8,
		4'd2, 4'd0, 4'd12, 4'd12, 4'd15, 4'd14, 4'd15, 4'd2};

	typedef struct packed {
		op_t                opcode;
		tap_t               target_state;
		logic [DATA_W-1:0]  shift_data;
		cnt_t               bit_count;
		logic               exit_shift;
		logic               keep_tdi;
	} cmd_t;

	typedef struct packed {
		logic tms_level;
		logic tdi_level;
		logic run_last;
		tap_t tap_state_now;
	} res_t;

	// Inputs of the per-period step unit
	typedef struct packed {
		op_t  op;
		tap_t state;
		tap_t target;
		logic data_bit;
		logic cnt_one;
		logic exit_shift;
		logic keep_tdi;
		logic last_tms;
		logic last_tdi;
	} step_in_t;

	typedef struct packed {
		logic tms;
		logic tdi;
		logic fin;
		tap_t nxt;
	} step_out_t;

	// TMS level that moves from s one edge closer to t (s differs from t)
	function automatic logic goto_tms(tap_t s, tap_t t);
		logic r;
		r = 1'b1;
		case (s)
			ST_TLR:      r = 1'b0;
			ST_RTI:      r = 1'b1;
			ST_SEL_DR:   r = !(t >= ST_CAP_DR && t <= ST_UPD_DR);
			ST_SEL_IR:   r = !(t >= ST_CAP_IR && t <= ST_UPD_IR);
			ST_CAP_DR:   r = (t != ST_SHIFT_DR);
			ST_CAP_IR:   r = (t != ST_SHIFT_IR);
			ST_EXIT1_DR: r = !(t >= ST_SHIFT_DR && t <= ST_EXIT2_DR);
			ST_EXIT1_IR: r = !(t >= ST_SHIFT_IR && t <= ST_EXIT2_IR);
			ST_EXIT2_DR: r = !(t >= ST_SHIFT_DR && t <= ST_PAUSE_DR);
			ST_EXIT2_IR: r = !(t >= ST_SHIFT_IR && t <= ST_PAUSE_IR);
			ST_UPD_DR,
			ST_UPD_IR:   r = (t != ST_RTI);
			default:     r = 1'b1;
		endcase
		return r;
	endfunction

endpackage

### hdl/jts_if.sv
// Request and result channel interfaces of the JTAG sequencer.
// Depends on jts_pkg for the payload types.
interface jts_cmd_if;
	import jts_pkg::*;
	logic valid;
	logic ready;
	cmd_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface jts_res_if;
	import jts_pkg::*;
	logic valid;
	logic ready;
	res_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hdl/jtag_tap_sequencer_top.sv
// Top level of the JTAG master sequencer: request latch, period sequencer, result register.
// Depends on jts_pkg, jts_if.sv and jts_step.
//
//  channel | dir | payload                                            | handshake
//  --------+-----+----------------------------------------------------+-----------
//  cmd     | in  | opcode, target_state, shift_data, bit_count,       | valid/ready
//          |     | exit_shift, keep_tdi                               |
//  res     | out | tms_level, tdi_level, run_last, tap_state_now      | valid/ready
//
// A request is taken while the block is idle; it then yields one result per cycle, unless res
// stalls, through the shared step unit and the single result register.
// Requests that yield no period (goto to the current state, zero count) leave the block idle.
// cmd.ready is low while a request is being sequenced; a stalled res holds the sequencer.
// Reset puts the tracked TAP state in Test-Logic-Reset and clears TMS and TDI history.
module jtag_tap_sequencer_top (
	input  logic      clk,
	input  logic      arst_n,
	jts_cmd_if.sink   cmd,
	jts_res_if.source res
);
	import jts_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic              state_q;
	op_t               op_q;
	tap_t              target_q;
	logic [DATA_W-1:0] data_q;
	cnt_t              cnt_q;
	logic              exit_q;
	logic              keep_q;

	tap_t              tap_state_q;
	logic              last_tms_q;
	logic              last_tdi_q;

	logic              res_valid_q;
	res_t              res_q;

	logic              take;
	logic              step_go;
	cnt_t              cnt_init;
	logic              has_work;
	step_in_t          si;
	step_out_t         so;

	assign cmd.ready   = (state_q == S_IDLE);
	assign take        = cmd.valid && cmd.ready;
	assign res.valid   = res_valid_q;
	assign res.payload = res_q;

	// advance one period whenever the result register is free or being drained
	assign step_go = (state_q == S_RUN) && (!res_valid_q || res.ready);

	// number of periods the new request asks for (goto ends on reaching its target)
	always_comb begin
		cnt_init = '0;
		case (cmd.payload.opcode)
			OP_RESET: cnt_init = CNT_W'(RESET_CLOCKS);
			OP_SHIFT: cnt_init = (cmd.payload.bit_count > CNT_W'(SHIFT_WIDTH)) ?
				CNT_W'(SHIFT_WIDTH) : cmd.payload.bit_count;
			OP_IDLE:  cnt_init = (cmd.payload.bit_count > CNT_W'(MAX_IDLE)) ?
				CNT_W'(MAX_IDLE) : cmd.payload.bit_count;
			default:  cnt_init = '0;
		endcase
	end

	assign has_work = (cmd.payload.opcode == OP_GOTO) ?
		(cmd.payload.target_state != tap_state_q) : (cnt_init != '0);

	assign si.op         = op_q;
	assign si.state      = tap_state_q;
	assign si.target     = target_q;
	assign si.data_bit   = data_q[0];
	assign si.cnt_one    = (cnt_q == CNT_W'(1));
	assign si.exit_shift = exit_q;
	assign si.keep_tdi   = keep_q;
	assign si.last_tms   = last_tms_q;
	assign si.last_tdi   = last_tdi_q;

	jts_step u_step (
		.si (si),
		.so (so)
	);

	// sequencer and tracked JTAG history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tap_state_q <= ST_TLR;
			last_tms_q  <= 1'b0;
			last_tdi_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						// goto drives TDI high even when no step is needed
						if (cmd.payload.opcode == OP_GOTO) begin
							last_tdi_q <= 1'b1;
						end
						if (has_work) begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (step_go) begin
						tap_state_q <= so.nxt;
						last_tms_q  <= so.tms;
						last_tdi_q  <= so.tdi;
						if (so.fin) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request payload: latch on take, then consume one bit and one count per period
	always_ff @(posedge clk) begin
		if (take) begin
			op_q     <= cmd.payload.opcode;
			target_q <= cmd.payload.target_state;
			data_q   <= cmd.payload.shift_data;
			cnt_q    <= cnt_init;
			exit_q   <= cmd.payload.exit_shift;
			keep_q   <= cmd.payload.keep_tdi;
		end else if (step_go) begin
			data_q <= data_q >> 1;
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

	// result register: load a new period, drop the flag once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_go) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			res_q.tms_level     <= so.tms;
			res_q.tdi_level     <= so.tdi;
			res_q.run_last      <= so.fin;
			res_q.tap_state_now <= so.nxt;
		end
	end

	// a last period always returns the sequencer to idle
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step_go && so.fin |=> state_q == S_IDLE)
		else $error("sequencer still running after last period");

	// a TAP reset always finishes in Test-Logic-Reset
	a_reset_tlr: assert property (@(posedge clk) disable iff (!arst_n)
		step_go && so.fin && op_q == OP_RESET |=> res.payload.tap_state_now == ST_TLR)
		else $error("TAP reset did not reach Test-Logic-Reset");

	// a shift with exit leaves the TAP in an Exit1 state
	a_shift_exit: assert property (@(posedge clk) disable iff (!arst_n)
		step_go && so.fin && op_q == OP_SHIFT && exit_q |=>
		tap_state_q == ST_EXIT1_DR || tap_state_q == ST_EXIT1_IR)
		else $error("shift exit did not land in Exit1");

endmodule

### hdl/jts_step.sv
// Shared step unit: works out one TCK period (TMS, TDI, next TAP state, last flag).
// Depends on jts_pkg.
module jts_step (
	input  jts_pkg::step_in_t  si,
	output jts_pkg::step_out_t so
);
	import jts_pkg::*;

	logic leave;

	assign leave = si.cnt_one && si.exit_shift;

	always_comb begin
		so = '0;
		unique case (si.op)
			OP_GOTO: begin
				so.tms = goto_tms(si.state, si.target);
				so.tdi = 1'b1;
				so.nxt = so.tms ? NEXT_TMS1[si.state] : NEXT_TMS0[si.state];
				so.fin = (so.nxt == si.target);
			end
			OP_RESET: begin
				so.tms = 1'b1;
				so.tdi = si.last_tdi;
				so.nxt = NEXT_TMS1[si.state];
				so.fin = si.cnt_one;
			end
			OP_SHIFT: begin
				so.tms = leave ? 1'b1 : si.last_tms;
				so.tdi = si.keep_tdi ? si.last_tdi : si.data_bit;
				// leave to Exit1-DR from Shift-DR, and to Exit1-IR from any other state
				if (leave) begin
					so.nxt = (si.state == ST_SHIFT_DR) ? ST_EXIT1_DR : ST_EXIT1_IR;
				end else begin
					so.nxt = si.state;
				end
				so.fin = si.cnt_one;
			end
			OP_IDLE: begin
				so.tms = (si.state == ST_TLR);
				so.tdi = 1'b0;
				so.nxt = si.state;
				so.fin = si.cnt_one;
			end
			default: so = '0;
		endcase
	end

endmodule

### tb/jtag_tap_sequencer_top_tb.sv
// Self-checking testbench for the JTAG master sequencer: walks the TAP graph,
// shifts, idles and resets, and checks every TCK period against its own tracker.
// Depends on jts_pkg, jts_if.sv and jtag_tap_sequencer_top.
module jtag_tap_sequencer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import jts_pkg::*;

	localparam int   CYCLE_LIMIT  = 1_000_000;
	localparam int   DRAIN_CYCLES = MAX_IDLE + 16;
	localparam int   RANDOM_ITEMS = 145;

	logic clk = 1'b0;
	logic arst_n;

	jts_cmd_if cmd_ch ();
	jts_res_if res_ch ();

	jtag_tap_sequencer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	always #10 clk = ~clk;

	// Tracked copy of the sequencer's state, advanced as each request is accepted
	tap_t tap_track;
	logic tms_hist;
	logic tdi_hist;

	// TCK periods still owed by the block, oldest first
	res_t pending_periods [$];

	int fail_count  = 0;
	int cycle_count = 0;
	int burst_left  = 0;
	int last_periods;

	// ---------------------------------------------------------------------------------------
	// TAP graph and path choice
	// ---------------------------------------------------------------------------------------

	// One edge of the standard TAP state graph
	function automatic tap_t tap_next(tap_t s, logic tms);
		tap_t n;
		case (s)
			ST_TLR:      n = tms ? ST_TLR      : ST_RTI;
			ST_RTI:      n = tms ? ST_SEL_DR   : ST_RTI;
			ST_SEL_DR:   n = tms ? ST_SEL_IR   : ST_CAP_DR;
			ST_CAP_DR:   n = tms ? ST_EXIT1_DR : ST_SHIFT_DR;
			ST_SHIFT_DR: n = tms ? ST_EXIT1_DR : ST_SHIFT_DR;
			ST_EXIT1_DR: n = tms ? ST_UPD_DR   : ST_PAUSE_DR;
			ST_PAUSE_DR: n = tms ? ST_EXIT2_DR : ST_PAUSE_DR;
			ST_EXIT2_DR: n = tms ? ST_UPD_DR   : ST_SHIFT_DR;
			ST_UPD_DR:   n = tms ? ST_SEL_DR   : ST_RTI;
			ST_SEL_IR:   n = tms ? ST_TLR      : ST_CAP_IR;
			ST_CAP_IR:   n = tms ? ST_EXIT1_IR : ST_SHIFT_IR;
			ST_SHIFT_IR: n = tms ? ST_EXIT1_IR : ST_SHIFT_IR;
			ST_EXIT1_IR: n = tms ? ST_UPD_IR   : ST_PAUSE_IR;
			ST_PAUSE_IR: n = tms ? ST_EXIT2_IR : ST_PAUSE_IR;
			ST_EXIT2_IR: n = tms ? ST_UPD_IR   : ST_SHIFT_IR;
			default:     n = tms ? ST_SEL_DR   : ST_RTI;
		endcase
		return n;
	endfunction

	// TMS level that takes s one edge nearer to t
	function automatic logic tms_toward(tap_t s, tap_t t);
		logic tms;
		case (s)
			ST_TLR:      tms = 1'b0;
			ST_RTI:      tms = 1'b1;
			ST_SEL_DR:   tms = (t < ST_CAP_DR) || (t > ST_UPD_DR);
			ST_SEL_IR:   tms = (t < ST_CAP_IR) || (t > ST_UPD_IR);
			ST_CAP_DR:   tms = (t != ST_SHIFT_DR);
			ST_CAP_IR:   tms = (t != ST_SHIFT_IR);
			ST_EXIT1_DR: tms = (t < ST_SHIFT_DR) || (t > ST_EXIT2_DR);
			ST_EXIT1_IR: tms = (t < ST_SHIFT_IR) || (t > ST_EXIT2_IR);
			ST_EXIT2_DR: tms = (t < ST_SHIFT_DR) || (t > ST_PAUSE_DR);
			ST_EXIT2_IR: tms = (t < ST_SHIFT_IR) || (t > ST_PAUSE_IR);
			ST_UPD_DR,
			ST_UPD_IR:   tms = (t != ST_RTI);
			default:     tms = 1'b1;
		endcase
		return tms;
	endfunction

	function automatic void push_period(logic tms, logic tdi, logic fin, tap_t st);
		res_t r;
		r.tms_level     = tms;
		r.tdi_level     = tdi;
		r.run_last      = fin;
		r.tap_state_now = st;
		pending_periods.push_back(r);
	endfunction

	// ---------------------------------------------------------------------------------------
	// Prediction: queue the TCK periods one accepted request produces, return how many
	// ---------------------------------------------------------------------------------------
	function automatic int predict_tck_periods(cmd_t c);
		int   n;
		int   len;
		logic tms;
		logic tdi;
		logic fin;
		tap_t st;
		n = 0;
		case (c.opcode)
			OP_GOTO: begin
				// TDI goes high even when the TAP already sits at the target
				tdi_hist = 1'b1;
				for (int i = 0; i < 16 && tap_track != c.target_state; i++) begin
					tms       = tms_toward(tap_track, c.target_state);
					tap_track = tap_next(tap_track, tms);
					tms_hist  = tms;
					fin       = (tap_track == c.target_state) || (i == 15);
					push_period(tms, 1'b1, fin, tap_track);
					n++;
				end
			end
			OP_RESET: begin
				st = tap_track;
				for (int i = 0; i < RESET_CLOCKS; i++) begin
					st = tap_next(st, 1'b1);
					push_period(1'b1, tdi_hist, i == RESET_CLOCKS - 1, st);
					n++;
				end
				tap_track = ST_TLR;
				tms_hist  = 1'b1;
			end
			OP_SHIFT: begin
				len = (c.bit_count > SHIFT_WIDTH) ? SHIFT_WIDTH : int'(c.bit_count);
				for (int i = 0; i < len; i++) begin
					fin = (i == len - 1);
					tms = tms_hist;
					tdi = c.keep_tdi ? tdi_hist : c.shift_data[i];
					// leaving on the last bit: Exit1-DR from Shift-DR, Exit1-IR from anywhere else
					if (fin && c.exit_shift) begin
						tms       = 1'b1;
						tap_track = (tap_track == ST_SHIFT_DR) ? ST_EXIT1_DR : ST_EXIT1_IR;
					end
					tms_hist = tms;
					tdi_hist = tdi;
					push_period(tms, tdi, fin, tap_track);
					n++;
				end
			end
			default: begin
				len = (c.bit_count > MAX_IDLE) ? MAX_IDLE : int'(c.bit_count);
				tms = (tap_track == ST_TLR);
				for (int i = 0; i < len; i++) begin
					push_period(tms, 1'b0, i == len - 1, tap_track);
					n++;
				end
				if (len > 0) begin
					tms_hist = tms;
					tdi_hist = 1'b0;
				end
			end
		endcase
		return n;
	endfunction

	// ---------------------------------------------------------------------------------------
	// Request side: drive at the falling edge, in bursts with random gaps between them
	// ---------------------------------------------------------------------------------------
	task automatic issue(input op_t op, input tap_t target, input logic [DATA_W-1:0] data,
			input cnt_t count, input logic ex, input logic keep);
		cmd_t c;
		int   gap;
		c.opcode       = op;
		c.target_state = target;
		c.shift_data   = data;
		c.bit_count    = count;
		c.exit_shift   = ex;
		c.keep_tdi     = keep;
		// start a new burst: drop valid for a random gap, or none at all
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				cmd_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		cmd_ch.valid   = 1'b1;
		cmd_ch.payload = c;
		// hold the request until the block takes it
		do @(posedge clk); while (!cmd_ch.ready);
		last_periods = predict_tck_periods(c);
		burst_left--;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------------------------------
	// Result side: stall pattern of its own, changing character every so often
	// ---------------------------------------------------------------------------------------
	int stall_mode  = 0;
	int stall_left  = 0;
	int stall_phase = 0;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(40, 200);
		end
		stall_left--;
		stall_phase++;
		case (stall_mode)
			0:       res_ch.ready <= 1'b1;
			1:       res_ch.ready <= 1'($urandom_range(0, 1));
			2:       res_ch.ready <= (stall_phase % 5) < 3;
			default: res_ch.ready <= (stall_phase % 8) == 0;
		endcase
	end

	// Check every accepted period against the oldest one owed
	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_periods.size() == 0) begin
				$error("unexpected TCK period: tms %0b tdi %0b run_last %0b state %0d",
					res_ch.payload.tms_level, res_ch.payload.tdi_level,
					res_ch.payload.run_last, res_ch.payload.tap_state_now);
				fail_count++;
			end else begin
				want = pending_periods.pop_front();
				if (res_ch.payload.tms_level !== want.tms_level) begin
					$error("tms_level: expected %0b, got %0b",
						want.tms_level, res_ch.payload.tms_level);
					fail_count++;
				end
				if (res_ch.payload.tdi_level !== want.tdi_level) begin
					$error("tdi_level: expected %0b, got %0b",
						want.tdi_level, res_ch.payload.tdi_level);
					fail_count++;
				end
				if (res_ch.payload.run_last !== want.run_last) begin
					$error("run_last: expected %0b, got %0b",
						want.run_last, res_ch.payload.run_last);
					fail_count++;
				end
				if (res_ch.payload.tap_state_now !== want.tap_state_now) begin
					$error("tap_state_now: expected %0d, got %0d",
						want.tap_state_now, res_ch.payload.tap_state_now);
					fail_count++;
				end
			end
		end
	end

	// Hard stop should the block hang
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------------

	// Goto across both columns, starting with a goto to the current state (no periods)
	task automatic test_goto_walk();
		issue(OP_GOTO, ST_TLR,      32'h0, 7'd0, 1'b0, 1'b0);
		issue(OP_GOTO, ST_RTI,      32'h0, 7'd0, 1'b0, 1'b0);
		issue(OP_GOTO, ST_UPD_IR,   32'h0, 7'd0, 1'b0, 1'b0);
		issue(OP_GOTO, ST_PAUSE_IR, 32'h0, 7'd0, 1'b0, 1'b0);
		issue(OP_GOTO, ST_EXIT2_DR, 32'h0, 7'd0, 1'b0, 1'b0);
		issue(OP_GOTO, ST_SEL_IR,   32'h0, 7'd0, 1'b0, 1'b0);
		issue(OP_GOTO, ST_TLR,      32'h0, 7'd0, 1'b0, 1'b0);
	endtask

	// Reset from Test-Logic-Reset, then from deep in the DR column with TDI history high
	task automatic test_reset_tap();
		issue(OP_RESET, ST_TLR,      32'h0, 7'd0, 1'b0, 1'b0);
		issue(OP_GOTO,  ST_EXIT1_DR, 32'h0, 7'd0, 1'b0, 1'b0);
		issue(OP_RESET, ST_UPD_IR,   32'hFFFF_FFFF, 7'd127, 1'b1, 1'b1);
	endtask

	// Full-width shifts of all ones and all zeros, count saturation, kept TDI, zero count,
	// and exit from a state other than Shift-DR
	task automatic test_shift_edges();
		issue(OP_GOTO,  ST_SHIFT_DR, 32'h0,         7'd0,   1'b0, 1'b0);
		issue(OP_SHIFT, ST_TLR,      32'hFFFF_FFFF, 7'd32,  1'b0, 1'b0);
		issue(OP_SHIFT, ST_TLR,      32'h0000_0000, 7'd32,  1'b0, 1'b0);
		issue(OP_SHIFT, ST_TLR,      32'hA5A5_A5A5, 7'd127, 1'b1, 1'b0);
		issue(OP_GOTO,  ST_SHIFT_IR, 32'h0,         7'd0,   1'b0, 1'b0);
		issue(OP_SHIFT, ST_UPD_IR,   32'h0000_0000, 7'd1,   1'b1, 1'b1);
		issue(OP_SHIFT, ST_UPD_IR,   32'hFFFF_FFFF, 7'd0,   1'b1, 1'b1);
		issue(OP_SHIFT, ST_TLR,      32'h5A5A_5A5A, 7'd64,  1'b1, 1'b0);
	endtask

	// Zero count, saturation above the idle limit, and TMS high in Test-Logic-Reset
	task automatic test_idle_edges();
		issue(OP_IDLE, ST_TLR, 32'h0, 7'd0,   1'b0, 1'b0);
		issue(OP_IDLE, ST_TLR, 32'h0, 7'd127, 1'b1, 1'b1);
		issue(OP_GOTO, ST_TLR, 32'h0, 7'd0,   1'b0, 1'b0);
		issue(OP_IDLE, ST_TLR, 32'h0, 7'd3,   1'b0, 1'b0);
		issue(OP_IDLE, ST_TLR, 32'h0, 7'd64,  1'b0, 1'b0);
	endtask

	// Just under half well-formed scans (goto shift state, shift, leave), the rest loose requests.
	// Only requests that produce periods count toward the total.
	task automatic test_random_traffic();
		int   sent;
		int   pick;
		tap_t shift_st;
		tap_t tgt;
		cnt_t cnt;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			tgt  = tap_t'($urandom_range(0, 15));
			if (pick < 45) begin
				shift_st = $urandom_range(0, 1) ? ST_SHIFT_DR : ST_SHIFT_IR;
				issue(OP_GOTO, shift_st, $urandom, cnt_t'($urandom_range(0, 127)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				if (last_periods > 0)
					sent++;
				repeat ($urandom_range(1, 2)) begin
					issue(OP_SHIFT, tgt, $urandom, cnt_t'($urandom_range(1, 32)),
						$urandom_range(0, 2) != 0, $urandom_range(0, 5) == 0);
					sent++;
				end
				// settle somewhere a real scan would go next
				case ($urandom_range(0, 3))
					0:       tgt = ST_RTI;
					1:       tgt = (shift_st == ST_SHIFT_DR) ? ST_PAUSE_DR : ST_PAUSE_IR;
					2:       tgt = (shift_st == ST_SHIFT_DR) ? ST_UPD_DR : ST_UPD_IR;
					default: tgt = tap_t'($urandom_range(0, 15));
				endcase
				issue(OP_GOTO, tgt, $urandom, cnt_t'($urandom_range(0, 127)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (pick < 60) begin
				issue(OP_GOTO, tgt, $urandom, cnt_t'($urandom_range(0, 127)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (pick < 68) begin
				issue(OP_RESET, tgt, $urandom, cnt_t'($urandom_range(0, 127)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else if (pick < 84) begin
				cnt = ($urandom_range(0, 7) == 0) ? cnt_t'($urandom_range(0, 127))
					: cnt_t'($urandom_range(0, 12));
				issue(OP_IDLE, tgt, $urandom, cnt, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else begin
				issue(OP_SHIFT, tgt, $urandom, cnt_t'($urandom_range(0, 127)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
			if (last_periods > 0)
				sent++;
		end
	endtask

	// ---------------------------------------------------------------------------------------
	// Sequence of the run
	// ---------------------------------------------------------------------------------------
	initial begin
		// hold every input at a known level before and during reset
		arst_n         = 1'b0;
		cmd_ch.valid   = 1'b0;
		cmd_ch.payload = '0;
		res_ch.ready   = 1'b0;
		tap_track      = ST_TLR;
		tms_hist       = 1'b0;
		tdi_hist       = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_goto_walk();
		test_reset_tap();
		test_shift_edges();
		test_idle_edges();
		test_random_traffic();

		// drop the request line and let the last periods drain
		cmd_ch.valid = 1'b0;
		while (pending_periods.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_periods.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
